### hw/rtl/maf_pkg.sv
package maf_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned WINDOW_W = 8;
  localparam int unsigned TOTAL_W  = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_OUTPUT
  } maf_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } maf_div_stat_t;

endpackage

### hw/rtl/maf_ram.sv
module maf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/maf_div.sv
module maf_div
  import maf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [TOTAL_W-1:0]  dividend,
  input  logic [WINDOW_W-1:0] divisor,
  output maf_div_stat_t       stat,
  output logic [TOTAL_W-1:0]  quotient
);

  localparam int unsigned CntW = $clog2(TOTAL_W + 1);

  logic [CntW-1:0]     cnt;
  logic [WINDOW_W-1:0] rem;
  logic [WINDOW_W-1:0] dvs;
  logic [TOTAL_W-1:0]  q;
  logic                busy;
  logic                done;

  logic [WINDOW_W:0]   shifted;
  logic [WINDOW_W:0]   diff;
  logic                fits;

  // Restoring division: the dividend shifts out of the top of q while
  // quotient bits shift in at the bottom, one bit per cycle.
  always_comb begin
    shifted = {rem, q[TOTAL_W-1]};
    diff    = shifted - {1'b0, dvs};
    fits    = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(TOTAL_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      q   <= {q[TOTAL_W-2:0], fits};
      rem <= fits ? diff[WINDOW_W-1:0] : shifted[WINDOW_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = q;

endmodule

### hw/rtl/moving_average_filter_core.sv
// Moving average over a ring of stored samples; one result per sample.
// Steps from the input transfer to a valid result: ring read, read-modify-write,
// serial divide, done flag and output load. A new sample is taken only once the
// previous result is in the output register, so a stalled output holds off input.
// Reset (synchronous, active high) sets the window to 8 (MAX_WINDOW if smaller) and clears the
// position, the running total and the ring fill flag; the ring is not swept.
module moving_average_filter_core
  import maf_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [WINDOW_W-1:0] cfg_data,      // window_size
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SAMPLE_W-1:0] s_axis_tdata,  // sample
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [SAMPLE_W-1:0] m_axis_tdata   // average
);

  localparam int unsigned PosW = $clog2(MAX_WINDOW);
  localparam logic [WINDOW_W-1:0] WinCap =
    WINDOW_W'((MAX_WINDOW > 255) ? 255 : MAX_WINDOW);
  localparam logic [WINDOW_W-1:0] WinReset =
    WINDOW_W'((MAX_WINDOW < 8) ? MAX_WINDOW : 8);

  maf_state_t          state;
  maf_state_t          state_next;

  logic [WINDOW_W-1:0] window;
  logic [PosW-1:0]     pos;
  logic                wrapped;
  logic [TOTAL_W-1:0]  total;
  logic [TOTAL_W-1:0]  total_next;
  logic [SAMPLE_W-1:0] sample;

  logic                ram_we;
  logic                ram_re;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [SAMPLE_W-1:0] old_sample;
  logic                pos_last;

  logic                div_start;
  maf_div_stat_t       div_stat;
  logic [TOTAL_W-1:0]  div_quotient;
  logic                out_load;

  assign cfg_ready = 1'b1;

  maf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos),
    .wdata (sample),
    .re    (ram_re),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  maf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total_next),
    .divisor  (window),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  // Until the position has wrapped once since the last restart, the slot at
  // the position has not been written and counts as zero.
  always_comb begin
    old_sample = wrapped ? ram_rdata : '0;
    total_next = total - TOTAL_W'(old_sample) + TOTAL_W'(sample);
    pos_last   = ((WINDOW_W + 1)'(pos) + 1'b1) == {1'b0, window};
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = ST_READ;
        end
      end
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_next = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_re        = 1'b1;
      end
      ST_UPDATE: begin
        ram_we    = 1'b1;
        div_start = 1'b1;
      end
      ST_OUTPUT: out_load = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window        <= WinReset;
      pos           <= '0;
      wrapped       <= 1'b0;
      total         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready && cfg_data != '0) begin
        window  <= (cfg_data > WinCap) ? WinCap : cfg_data;
        pos     <= '0;
        wrapped <= 1'b0;
        total   <= '0;
      end else if (state == ST_UPDATE) begin
        total <= total_next;
        if (pos_last) begin
          pos     <= '0;
          wrapped <= 1'b1;
        end else begin
          pos <= pos + 1'b1;
        end
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sample <= s_axis_tdata;
    end
    if (out_load) begin
      m_axis_tdata <= div_quotient[SAMPLE_W-1:0];
    end
  end

  a_pos_in_window: assert property (@(posedge clk) disable iff (rst)
    (WINDOW_W + 1)'(pos) < {1'b0, window})
    else $error("ring position outside the window");

  a_window_nonzero: assert property (@(posedge clk) disable iff (rst)
    window != '0)
    else $error("window length is zero");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state == ST_READ)
    else $error("input transfer did not start a ring read");

  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy || div_stat.done |-> state == ST_DIVIDE)
    else $error("divider active outside the divide phase");

  a_load_after_div: assert property (@(posedge clk) disable iff (rst)
    out_load |-> $past(state) == ST_DIVIDE || $past(state) == ST_OUTPUT)
    else $error("result loaded without a finished division");

endmodule

### tb/sv/tb_moving_average_filter_core.sv
module tb_moving_average_filter_core;
  import maf_pkg::*;

  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [WINDOW_W-1:0] cfg_data = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SAMPLE_W-1:0] s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_axis_tdata;

  // Mirror of the filter state, kept in step with accepted transfers.
  logic [SAMPLE_W-1:0] ring_mirror [RING_DEPTH];
  int unsigned         slot_mirror;
  logic [TOTAL_W-1:0]  total_mirror;
  int unsigned         window_mirror;

  logic [SAMPLE_W-1:0] sample_backlog[$];
  logic [SAMPLE_W-1:0] pending_averages[$];

  bit          sample_taken = 1'b0;
  bit          average_taken = 1'b0;
  bit          steady = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned averages_checked = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  moving_average_filter_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_mirror();
    for (int i = 0; i < RING_DEPTH; i++) ring_mirror[i] = '0;
    slot_mirror = 0;
    total_mirror = '0;
  endfunction

  // A zero window is ignored; any other value restarts the filter.
  function automatic void apply_window(input logic [WINDOW_W-1:0] len);
    if (len != '0) begin
      window_mirror = len;
      clear_mirror();
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] predict_average(input logic [SAMPLE_W-1:0] s);
    int unsigned p;
    logic [TOTAL_W-1:0] q;
    p = slot_mirror;
    if (p >= window_mirror) p = 0;
    total_mirror = total_mirror - TOTAL_W'(ring_mirror[p]) + TOTAL_W'(s);
    ring_mirror[p] = s;
    p = p + 1;
    if (p >= window_mirror) p = 0;
    slot_mirror = p;
    q = total_mirror / TOTAL_W'(window_mirror);
    return q[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return SAMPLE_W'($urandom);
      1: return $urandom_range(0, 1) ? FULL_SCALE : '0;
      2: return FULL_SCALE - SAMPLE_W'($urandom_range(0, 255));
      default: return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned draw_wait();
    return steady ? 0 : $urandom_range(0, 15);
  endfunction

  // Sample driver: a new transfer is offered only once the previous one is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !sample_taken) begin
      s_axis_tvalid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      s_axis_tvalid <= 1'b0;
    end else if (sample_backlog.size() > 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= sample_backlog.pop_front();
      send_gap <= draw_wait();
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Result receiver: short random stalls, plus a long hold-off now and then
  // so that the filter backs up and refuses samples.
  always @(negedge clk) begin
    int unsigned stall;
    stall = stall_left;
    if (average_taken) stall = draw_wait();
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (average_taken && (averages_checked == 150 || averages_checked == 900)) begin
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (stall > 0) begin
      stall_left <= stall - 1;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left <= 0;
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: predicts on each sample transfer and checks each average transfer.
  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    sample_taken = !rst && s_axis_tvalid && s_axis_tready;
    average_taken = !rst && m_axis_tvalid && m_axis_tready;
    if (sample_taken) pending_averages.push_back(predict_average(s_axis_tdata));
    if (average_taken) begin
      averages_checked++;
      if (pending_averages.size() == 0) begin
        $error("average: unexpected transfer, actual %0d", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_averages.pop_front();
        if (m_axis_tdata !== want) begin
          $error("average: expected %0d, actual %0d", want, m_axis_tdata);
          fail_count++;
        end
      end
    end
  end

  task automatic wait_idle();
    @(posedge clk);
    while (sample_backlog.size() != 0 || s_axis_tvalid || pending_averages.size() != 0)
      @(posedge clk);
  endtask

  task automatic load_window(input logic [WINDOW_W-1:0] len);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_window(len);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_samples(input int unsigned count);
    for (int i = 0; i < count; i++) sample_backlog.push_back(pick_sample());
  endtask

  initial begin
    logic [WINDOW_W-1:0] len;
    int unsigned count;
    window_mirror = 8;
    clear_mirror();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default window: warm-up from a cleared ring, then wrap with full-scale samples.
    repeat (9) sample_backlog.push_back(FULL_SCALE);
    sample_backlog.push_back('0);
    sample_backlog.push_back(16'd1);
    sample_backlog.push_back(16'h5555);
    sample_backlog.push_back(16'hAAAA);
    wait_idle();
    // A zero window write must leave the running state untouched.
    load_window('0);
    sample_backlog.push_back(16'h8000);
    sample_backlog.push_back(16'd7);
    wait_idle();
    load_window(8'd1);
    sample_backlog.push_back(FULL_SCALE);
    sample_backlog.push_back('0);
    sample_backlog.push_back(16'd12345);
    wait_idle();
    load_window(8'd255);
    repeat (3) sample_backlog.push_back(FULL_SCALE);
    sample_backlog.push_back(16'd1);
    wait_idle();

    // Widest window with enough samples to wrap the ring.
    load_window(8'd255);
    queue_samples(400);
    wait_idle();

    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 7))
        0: len = 8'd1;
        1: len = 8'd2;
        2: len = 8'd3;
        3: len = 8'd255;
        4: len = 8'd254;
        5: len = '0;
        6: len = WINDOW_W'($urandom_range(1, 16));
        default: len = WINDOW_W'($urandom_range(1, 255));
      endcase
      steady = (phase % 4 == 1);
      load_window(len);
      count = $urandom_range(90, 130);
      queue_samples(count);
      wait_idle();
    end
    steady = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_averages.size() != 0) begin
      $error("average: %0d expected transfers never arrived", pending_averages.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
